/* src/nrts_pkg.sv */
// Shared types and codes for the nested region timing statistics block.
`default_nettype none
package nrts_pkg;

  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_DEEP   = 3'd3;
  localparam logic [2:0] ST_BADTHR = 3'd4;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] res;
    logic        borrow;
  } alu_rsp_t;

endpackage
`default_nettype wire

/* src/nrts_if.sv */
// Request and result channel interfaces of the region timing block.
`default_nettype none
interface nrts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  thread_sel;
  logic [3:0]  region_index;
  logic [63:0] timestamp;
  logic [3:0]  read_level;
  modport source (output valid, req_type, thread_sel, region_index, timestamp, read_level,
                  input ready);
  modport sink (input valid, req_type, thread_sel, region_index, timestamp, read_level,
                output ready);
endinterface

interface nrts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] duration;
  logic [63:0] hit_count;
  logic [63:0] cycle_sum;
  logic [63:0] cycle_min;
  logic [63:0] cycle_max;
  logic [4:0]  levels_seen;
  modport source (output valid, status, duration, hit_count, cycle_sum, cycle_min, cycle_max,
                  levels_seen, input ready);
  modport sink (input valid, status, duration, hit_count, cycle_sum, cycle_min, cycle_max,
                levels_seen, output ready);
endinterface
`default_nettype wire

/* src/nrts_alu.sv */
// Shared 64-bit adder/subtractor used for durations, counts, sums and compares.
`default_nettype none
module nrts_alu (
  input  nrts_pkg::alu_req_t req_i,
  output nrts_pkg::alu_rsp_t rsp_o
);
  import nrts_pkg::*;

  logic        sub;
  logic [64:0] total;

  assign sub   = (req_i.op == ALU_SUB);
  assign total = {1'b0, req_i.a} + {1'b0, (sub ? ~req_i.b : req_i.b)} + {64'b0, sub};
  // On a subtract the carry out is set when no borrow occurred.
  assign rsp_o.res    = total[63:0];
  assign rsp_o.borrow = sub & ~total[64];
endmodule
`default_nettype wire

/* src/nested_region_timing_stats.sv */
// Top level: per-thread region stacks and per-level timing statistics records.
// An end event makes two record updates through the one shared 64-bit adder; one item
// at a time. After a result beat is taken the block returns to idle before it accepts
// the next item. Reset is asynchronous; afterwards a clearing pass over all
// (THREADS+1)*REGIONS*LEVELS statistics entries initializes the statistics, depth and
// nesting memories before ready rises.
`default_nettype none
module nested_region_timing_stats #(
  parameter int THREADS     = 4,
  parameter int REGIONS     = 16,
  parameter int LEVELS      = 16,
  parameter int STACK_DEPTH = 32
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  nrts_in_if.sink   in_i,
  nrts_out_if.source out_o
);
  import nrts_pkg::*;

  localparam int NUM_REC  = (THREADS + 1) * REGIONS;
  localparam int NUM_KEYS = NUM_REC * LEVELS;
  localparam int NUM_ND   = THREADS * REGIONS;
  localparam int NUM_STK  = THREADS * STACK_DEPTH;
  localparam int REG_W    = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int THR_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int REC_W    = (NUM_REC > 1) ? $clog2(NUM_REC) : 1;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ND_W     = (NUM_ND > 1) ? $clog2(NUM_ND) : 1;
  localparam int SK_W     = (NUM_STK > 1) ? $clog2(NUM_STK) : 1;
  localparam int FILL_W   = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECODE  = 4'd2;
  localparam logic [3:0] S_BEG     = 4'd3;
  localparam logic [3:0] S_END_POP = 4'd4;
  localparam logic [3:0] S_END_LVL = 4'd5;
  localparam logic [3:0] S_UPD_HIT = 4'd6;
  localparam logic [3:0] S_UPD_SUM = 4'd7;
  localparam logic [3:0] S_UPD_MIN = 4'd8;
  localparam logic [3:0] S_UPD_MAX = 4'd9;
  localparam logic [3:0] S_UPD_WR  = 4'd10;
  localparam logic [3:0] S_READ    = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  typedef logic [REG_W-1:0] reg_tbl_t [16];

  function automatic reg_tbl_t mk_reg_tbl();
    reg_tbl_t t;
    for (int i = 0; i < 16; i++) begin
      t[i] = REG_W'(i % REGIONS);
    end
    return t;
  endfunction

  localparam reg_tbl_t REG_TBL = mk_reg_tbl();

  // Control and captured request.
  logic [3:0]        state_q, state_d;
  logic [KEY_W-1:0]  clr_q, clr_d;
  logic [FILL_W-1:0] fill_q [THREADS];
  logic [FILL_W-1:0] fill_d [THREADS];
  logic [1:0]        req_q, req_d;
  logic [2:0]        thr_q, thr_d;
  logic [REG_W-1:0]  reg_q, reg_d;
  logic [63:0]       ts_q, ts_d;
  logic [3:0]        lvl_q, lvl_d;

  // Working registers of an end event.
  logic [REG_W-1:0]  rreg_q, rreg_d;
  logic [63:0]       durr_q, durr_d;
  logic [4:0]        level_q, level_d;
  logic [REC_W-1:0]  rec_q, rec_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic              glob_q, glob_d;
  logic [63:0]       nh_q, nh_d, ns_q, ns_d, nmin_q, nmin_d, nmax_q, nmax_d;

  // Result register.
  logic              ovalid_q, ovalid_d;
  logic [2:0]        ost_q, ost_d;
  logic [63:0]       odur_q, odur_d, ohit_q, ohit_d, osum_q, osum_d;
  logic [63:0]       omin_q, omin_d, omax_q, omax_d;
  logic [4:0]        olvs_q, olvs_d;

  // Memories and their ports.
  logic [63:0]      hits_mem [NUM_KEYS];
  logic [63:0]      sum_mem  [NUM_KEYS];
  logic [63:0]      min_mem  [NUM_KEYS];
  logic [63:0]      max_mem  [NUM_KEYS];
  logic [4:0]       dp_mem   [NUM_REC];
  logic [4:0]       nd_mem   [NUM_ND];
  logic [REG_W-1:0] stk_reg_mem [NUM_STK];
  logic [63:0]      stk_ts_mem  [NUM_STK];

  logic             st_we, st_re, dp_we, dp_re, nd_we, nd_re, stk_we, stk_re;
  logic [KEY_W-1:0] st_wa, st_ra;
  logic [REC_W-1:0] dp_wa, dp_ra;
  logic [ND_W-1:0]  nd_wa, nd_ra;
  logic [SK_W-1:0]  stk_wa, stk_ra;
  logic [63:0]      hits_wd, sum_wd, min_wd, max_wd;
  logic [4:0]       dp_wd, nd_wd;
  logic [63:0]      hits_rd, sum_rd, min_rd, max_rd, stk_ts_rd;
  logic [4:0]       dp_rd, nd_rd;
  logic [REG_W-1:0] stk_reg_rd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  nrts_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  logic [THR_W-1:0]  thr_idx;
  logic [FILL_W-1:0] fill_cur;
  logic              thr_bad;
  logic [4:0]        lvl1;
  logic [REC_W-1:0]  rec_new;
  logic [REC_W-1:0]  rec_rd;

  assign thr_idx  = THR_W'(thr_q);
  assign fill_cur = fill_q[thr_idx];
  assign thr_bad  = (32'(thr_q) >= THREADS);
  assign lvl1     = (nd_rd == 5'd0) ? 5'd1 : nd_rd;
  assign rec_new  = REC_W'(32'(thr_q) * REGIONS + 32'(rreg_q));
  assign rec_rd   = REC_W'(32'(thr_q) * REGIONS + 32'(reg_q));

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = ovalid_q;
  assign out_o.status       = ost_q;
  assign out_o.duration     = odur_q;
  assign out_o.hit_count    = ohit_q;
  assign out_o.cycle_sum    = osum_q;
  assign out_o.cycle_min    = omin_q;
  assign out_o.cycle_max    = omax_q;
  assign out_o.levels_seen  = olvs_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    fill_d   = fill_q;
    req_d    = req_q;
    thr_d    = thr_q;
    reg_d    = reg_q;
    ts_d     = ts_q;
    lvl_d    = lvl_q;
    rreg_d   = rreg_q;
    durr_d   = durr_q;
    level_d  = level_q;
    rec_d    = rec_q;
    key_d    = key_q;
    glob_d   = glob_q;
    nh_d     = nh_q;
    ns_d     = ns_q;
    nmin_d   = nmin_q;
    nmax_d   = nmax_q;
    ovalid_d = ovalid_q;
    ost_d    = ost_q;
    odur_d   = odur_q;
    ohit_d   = ohit_q;
    osum_d   = osum_q;
    omin_d   = omin_q;
    omax_d   = omax_q;
    olvs_d   = olvs_q;

    st_we = 1'b0; st_re = 1'b0; st_wa = '0; st_ra = '0;
    dp_we = 1'b0; dp_re = 1'b0; dp_wa = '0; dp_ra = '0;
    nd_we = 1'b0; nd_re = 1'b0; nd_wa = '0; nd_ra = '0;
    stk_we = 1'b0; stk_re = 1'b0; stk_wa = '0; stk_ra = '0;
    hits_wd = nh_q; sum_wd = ns_q; min_wd = nmin_q; max_wd = nmax_q;
    dp_wd = (dp_rd < level_q) ? level_q : dp_rd;
    nd_wd = '0;
    alu_req = '{op: ALU_ADD, a: 64'd0, b: 64'd0};

    unique case (state_q)
      S_CLEAR: begin
        st_we   = 1'b1;
        st_wa   = clr_q;
        hits_wd = 64'd0;
        sum_wd  = 64'd0;
        min_wd  = '1;
        max_wd  = 64'd0;
        dp_we   = (32'(clr_q) < NUM_REC);
        dp_wa   = REC_W'(clr_q);
        dp_wd   = 5'd0;
        nd_we   = (32'(clr_q) < NUM_ND);
        nd_wa   = ND_W'(clr_q);
        nd_wd   = 5'd0;
        clr_d   = clr_q + 1'b1;
        if (32'(clr_q) == NUM_KEYS - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          req_d   = in_i.req_type;
          thr_d   = in_i.thread_sel;
          reg_d   = REG_TBL[in_i.region_index];
          ts_d    = in_i.timestamp;
          lvl_d   = in_i.read_level;
          ost_d   = ST_OK;
          odur_d  = 64'd0;
          ohit_d  = 64'd0;
          osum_d  = 64'd0;
          omin_d  = 64'd0;
          omax_d  = 64'd0;
          olvs_d  = 5'd0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d  = S_OUT;
        ovalid_d = 1'b1;
        case (req_q)
          REQ_BEGIN: begin
            if (thr_bad) begin
              ost_d = ST_BADTHR;
            end else if (fill_cur == FILL_W'(STACK_DEPTH)) begin
              ost_d = ST_FULL;
            end else begin
              nd_re    = 1'b1;
              nd_ra    = ND_W'(rec_rd);
              ovalid_d = 1'b0;
              state_d  = S_BEG;
            end
          end
          REQ_END: begin
            if (thr_bad) begin
              ost_d = ST_BADTHR;
            end else if (fill_cur == '0) begin
              ost_d = ST_EMPTY;
            end else begin
              fill_d[thr_idx] = fill_cur - 1'b1;
              stk_re   = 1'b1;
              stk_ra   = SK_W'(32'(thr_q) * STACK_DEPTH + 32'(fill_cur) - 1);
              ovalid_d = 1'b0;
              state_d  = S_END_POP;
            end
          end
          REQ_READ: begin
            if (32'(thr_q) > THREADS) begin
              ost_d = ST_BADTHR;
            end else begin
              dp_re    = 1'b1;
              dp_ra    = rec_rd;
              st_re    = (32'(lvl_q) < LEVELS);
              st_ra    = KEY_W'(32'(rec_rd) * LEVELS + 32'(lvl_q));
              ovalid_d = 1'b0;
              state_d  = S_READ;
            end
          end
          default: begin
            ost_d = ST_OK;
          end
        endcase
      end
      S_BEG: begin
        state_d  = S_OUT;
        ovalid_d = 1'b1;
        if (nd_rd >= 5'(LEVELS)) begin
          ost_d = ST_DEEP;
        end else begin
          stk_we = 1'b1;
          stk_wa = SK_W'(32'(thr_q) * STACK_DEPTH + 32'(fill_cur));
          fill_d[thr_idx] = fill_cur + 1'b1;
          nd_we  = 1'b1;
          nd_wa  = ND_W'(rec_rd);
          nd_wd  = nd_rd + 5'd1;
        end
      end
      S_END_POP: begin
        alu_req = '{op: ALU_SUB, a: ts_q, b: stk_ts_rd};
        durr_d  = alu_rsp.res;
        rreg_d  = stk_reg_rd;
        nd_re   = 1'b1;
        nd_ra   = ND_W'(32'(thr_q) * REGIONS + 32'(stk_reg_rd));
        state_d = S_END_LVL;
      end
      S_END_LVL: begin
        level_d = lvl1;
        nd_we   = 1'b1;
        nd_wa   = ND_W'(rec_new);
        nd_wd   = lvl1 - 5'd1;
        rec_d   = rec_new;
        key_d   = KEY_W'(32'(rec_new) * LEVELS + 32'(lvl1) - 1);
        glob_d  = 1'b0;
        st_re   = 1'b1;
        st_ra   = KEY_W'(32'(rec_new) * LEVELS + 32'(lvl1) - 1);
        dp_re   = 1'b1;
        dp_ra   = rec_new;
        state_d = S_UPD_HIT;
      end
      S_UPD_HIT: begin
        alu_req = '{op: ALU_ADD, a: hits_rd, b: 64'd1};
        nh_d    = alu_rsp.res;
        state_d = S_UPD_SUM;
      end
      S_UPD_SUM: begin
        alu_req = '{op: ALU_ADD, a: sum_rd, b: durr_q};
        ns_d    = alu_rsp.res;
        state_d = S_UPD_MIN;
      end
      S_UPD_MIN: begin
        alu_req = '{op: ALU_SUB, a: durr_q, b: min_rd};
        nmin_d  = alu_rsp.borrow ? durr_q : min_rd;
        state_d = S_UPD_MAX;
      end
      S_UPD_MAX: begin
        alu_req = '{op: ALU_SUB, a: max_rd, b: durr_q};
        nmax_d  = alu_rsp.borrow ? durr_q : max_rd;
        state_d = S_UPD_WR;
      end
      S_UPD_WR: begin
        st_we = 1'b1;
        st_wa = key_q;
        dp_we = 1'b1;
        dp_wa = rec_q;
        if (!glob_q) begin
          // The global record of the region uses the thread's nesting level.
          glob_d  = 1'b1;
          rec_d   = REC_W'(THREADS * REGIONS + 32'(rreg_q));
          key_d   = KEY_W'((THREADS * REGIONS + 32'(rreg_q)) * LEVELS + 32'(level_q) - 1);
          st_re   = 1'b1;
          st_ra   = KEY_W'((THREADS * REGIONS + 32'(rreg_q)) * LEVELS + 32'(level_q) - 1);
          dp_re   = 1'b1;
          dp_ra   = REC_W'(THREADS * REGIONS + 32'(rreg_q));
          state_d = S_UPD_HIT;
        end else begin
          odur_d   = durr_q;
          ovalid_d = 1'b1;
          state_d  = S_OUT;
        end
      end
      S_READ: begin
        olvs_d = dp_rd;
        if (32'(lvl_q) < LEVELS) begin
          ohit_d = hits_rd;
          osum_d = sum_rd;
          omin_d = min_rd;
          omax_d = max_rd;
        end else begin
          omin_d = '1;
        end
        ovalid_d = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          ovalid_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
      for (int t = 0; t < THREADS; t++) begin
        fill_q[t] <= '0;
      end
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ovalid_q <= ovalid_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    thr_q   <= thr_d;
    reg_q   <= reg_d;
    ts_q    <= ts_d;
    lvl_q   <= lvl_d;
    rreg_q  <= rreg_d;
    durr_q  <= durr_d;
    level_q <= level_d;
    rec_q   <= rec_d;
    key_q   <= key_d;
    glob_q  <= glob_d;
    nh_q    <= nh_d;
    ns_q    <= ns_d;
    nmin_q  <= nmin_d;
    nmax_q  <= nmax_d;
    ost_q   <= ost_d;
    odur_q  <= odur_d;
    ohit_q  <= ohit_d;
    osum_q  <= osum_d;
    omin_q  <= omin_d;
    omax_q  <= omax_d;
    olvs_q  <= olvs_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      hits_mem[st_wa] <= hits_wd;
      sum_mem[st_wa]  <= sum_wd;
      min_mem[st_wa]  <= min_wd;
      max_mem[st_wa]  <= max_wd;
    end
    if (st_re) begin
      hits_rd <= hits_mem[st_ra];
      sum_rd  <= sum_mem[st_ra];
      min_rd  <= min_mem[st_ra];
      max_rd  <= max_mem[st_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_we) begin
      dp_mem[dp_wa] <= dp_wd;
    end
    if (dp_re) begin
      dp_rd <= dp_mem[dp_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nd_we) begin
      nd_mem[nd_wa] <= nd_wd;
    end
    if (nd_re) begin
      nd_rd <= nd_mem[nd_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_reg_mem[stk_wa] <= reg_q;
      stk_ts_mem[stk_wa]  <= ts_q;
    end
    if (stk_re) begin
      stk_reg_rd <= stk_reg_mem[stk_ra];
      stk_ts_rd  <= stk_ts_mem[stk_ra];
    end
  end

endmodule
`default_nettype wire

/* src/nrts_chk.sv */
// Port-level checker for the region timing block, bound to the top level.
`default_nettype none
module nrts_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  status,
  input wire [63:0] duration,
  input wire [63:0] hit_count,
  input wire [63:0] cycle_sum,
  input wire [4:0]  levels_seen
);
  import nrts_pkg::*;

  // One item at a time: no new beat is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted beat");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != ST_OK |-> duration == 64'd0 && hit_count == 64'd0 &&
      cycle_sum == 64'd0 && levels_seen == 5'd0)
    else $error("error result carries nonzero fields");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(duration))
    else $error("stalled result changed");

endmodule

bind nested_region_timing_stats nrts_chk u_nrts_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .status      (out_o.status),
  .duration    (out_o.duration),
  .hit_count   (out_o.hit_count),
  .cycle_sum   (out_o.cycle_sum),
  .levels_seen (out_o.levels_seen)
);
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking testbench for the nested region timing statistics block.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nrts_pkg::*;

  localparam int THREADS = 4;
  localparam int REGIONS = 16;
  localparam int LEVELS = 16;
  localparam int STACK_DEPTH = 32;
  localparam int NREC = (THREADS + 1) * REGIONS;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  req;
    logic [2:0]  thr;
    logic [3:0]  reg_idx;
    logic [63:0] ts;
    logic [3:0]  lvl;
  } event_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] duration;
    logic [63:0] hits;
    logic [63:0] sum;
    logic [63:0] min;
    logic [63:0] max;
    logic [4:0]  seen;
  } stats_t;

  typedef struct packed {
    event_t ev;
    logic   has_exp;
    stats_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  nrts_in_if  req_ch ();
  nrts_out_if res_ch ();

  nested_region_timing_stats u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (res_ch.source)
  );

  // Shadow state of the block.
  logic [3:0]  sh_region [THREADS][STACK_DEPTH];
  logic [63:0] sh_stamp  [THREADS][STACK_DEPTH];
  int          sh_fill   [THREADS];
  int          sh_depth  [THREADS][REGIONS];
  logic [63:0] sh_hits   [NREC][LEVELS];
  logic [63:0] sh_sum    [NREC][LEVELS];
  logic [63:0] sh_min    [NREC][LEVELS];
  logic [63:0] sh_max    [NREC][LEVELS];
  int          sh_deep   [NREC];

  stats_t pending_results[$];
  int     errors = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  bit     hold_off = 1'b0;

  function automatic void clear_shadow();
    for (int t = 0; t < THREADS; t++) begin
      sh_fill[t] = 0;
      for (int r = 0; r < REGIONS; r++) sh_depth[t][r] = 0;
    end
    for (int r = 0; r < NREC; r++) begin
      sh_deep[r] = 0;
      for (int l = 0; l < LEVELS; l++) begin
        sh_hits[r][l] = '0;
        sh_sum[r][l] = '0;
        sh_min[r][l] = '1;
        sh_max[r][l] = '0;
      end
    end
  endfunction

  function automatic void add_to_record(int rec, int level, logic [63:0] dur);
    int k;
    k = level - 1;
    if (sh_deep[rec] < level) sh_deep[rec] = level;
    sh_hits[rec][k] += 64'd1;
    sh_sum[rec][k] += dur;
    if (dur < sh_min[rec][k]) sh_min[rec][k] = dur;
    if (dur > sh_max[rec][k]) sh_max[rec][k] = dur;
  endfunction

  function automatic stats_t predict_stats(event_t ev);
    stats_t o;
    int t, r, lv, rec;
    logic [3:0] open_r;
    o = '0;
    t = ev.thr;
    r = ev.reg_idx % REGIONS;
    case (ev.req)
      REQ_BEGIN: begin
        if (t >= THREADS) o.status = ST_BADTHR;
        else if (sh_fill[t] >= STACK_DEPTH) o.status = ST_FULL;
        else if (sh_depth[t][r] >= LEVELS) o.status = ST_DEEP;
        else begin
          sh_region[t][sh_fill[t]] = 4'(r);
          sh_stamp[t][sh_fill[t]] = ev.ts;
          sh_fill[t]++;
          sh_depth[t][r]++;
        end
      end
      REQ_END: begin
        if (t >= THREADS) o.status = ST_BADTHR;
        else if (sh_fill[t] == 0) o.status = ST_EMPTY;
        else begin
          sh_fill[t]--;
          open_r = sh_region[t][sh_fill[t]];
          o.duration = ev.ts - sh_stamp[t][sh_fill[t]];
          lv = sh_depth[t][open_r];
          if (lv == 0) lv = 1;
          add_to_record(t * REGIONS + open_r, lv, o.duration);
          add_to_record(THREADS * REGIONS + open_r, lv, o.duration);
          sh_depth[t][open_r] = lv - 1;
        end
      end
      REQ_READ: begin
        if (t > THREADS) o.status = ST_BADTHR;
        else begin
          rec = t * REGIONS + r;
          o.seen = 5'(sh_deep[rec]);
          if (ev.lvl < LEVELS) begin
            o.hits = sh_hits[rec][ev.lvl];
            o.sum = sh_sum[rec][ev.lvl];
            o.min = sh_min[rec][ev.lvl];
            o.max = sh_max[rec][ev.lvl];
          end else o.min = '1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Result side: random stalls, a long hold-off on request, and the checks.
  initial res_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    if (res_ch.valid && res_ch.ready) begin
      stats_t got, want;
      got = {res_ch.status, res_ch.duration, res_ch.hit_count, res_ch.cycle_sum,
             res_ch.cycle_min, res_ch.cycle_max, res_ch.levels_seen};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
        end
        if (got.duration !== want.duration) begin
          errors++;
          $display("%0t: duration exp %h got %h", $realtime, want.duration, got.duration);
        end
        if (got.hits !== want.hits) begin
          errors++;
          $display("%0t: hit_count exp %h got %h", $realtime, want.hits, got.hits);
        end
        if (got.sum !== want.sum) begin
          errors++;
          $display("%0t: cycle_sum exp %h got %h", $realtime, want.sum, got.sum);
        end
        if (got.min !== want.min) begin
          errors++;
          $display("%0t: cycle_min exp %h got %h", $realtime, want.min, got.min);
        end
        if (got.max !== want.max) begin
          errors++;
          $display("%0t: cycle_max exp %h got %h", $realtime, want.max, got.max);
        end
        if (got.seen !== want.seen) begin
          errors++;
          $display("%0t: levels_seen exp %0d got %0d", $realtime, want.seen, got.seen);
        end
      end
    end
    res_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // The hold-off counts its own cycles so the sender keeps offering beats meanwhile.
  task automatic hold_results(int cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  initial begin
    longint unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Valid stays high after an accepted beat until the next beat or an idle cycle replaces it.
  task automatic send_event(event_t ev, bit has_exp = 1'b0, stats_t fixed = '0);
    stats_t p;
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= ev.req;
    req_ch.thread_sel <= ev.thr;
    req_ch.region_index <= ev.reg_idx;
    req_ch.timestamp <= ev.ts;
    req_ch.read_level <= ev.lvl;
    do @(posedge clk_i); while (!req_ch.ready);
    p = predict_stats(ev);
    pending_results.push_back(has_exp ? fixed : p);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_stamp();
    case ($urandom_range(3))
      0: return rand64();
      1: return '1 - 64'($urandom_range(50));
      default: return 64'($urandom_range(100000));
    endcase
  endfunction

  // Random begins and ends on random threads, with reads and noise mixed in.
  task automatic random_events(int n);
    event_t ev;
    int k;
    for (int i = 0; i < n; i++) begin
      ev.ts = rand_stamp();
      ev.lvl = 4'($urandom_range(15));
      ev.reg_idx = 4'($urandom_range(15));
      ev.thr = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
      k = $urandom_range(99);
      if (k < 42) ev.req = REQ_BEGIN;
      else if (k < 80) ev.req = REQ_END;
      else if (k < 97) ev.req = REQ_READ;
      else ev.req = REQ_UNUSED;
      if (ev.req == REQ_READ && $urandom_range(1)) ev.lvl = 4'($urandom_range(3));
      send_event(ev);
    end
  endtask

  row_t dir_rows[$];
  row_t rw;
  event_t ev;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_BEGIN;
    req_ch.thread_sel = '0;
    req_ch.region_index = '0;
    req_ch.timestamp = '0;
    req_ch.read_level = '0;
    clear_shadow();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; typed expectations where obvious, else the predictor decides.
    dir_rows = '{
      '{'{REQ_READ, 3'd0, 4'd0, 64'd0, 4'd0}, 1'b1, '{ST_OK, 0, 0, 0, '1, 0, 0}},
      '{'{REQ_READ, 3'd4, 4'd15, 64'd0, 4'd15}, 1'b1, '{ST_OK, 0, 0, 0, '1, 0, 0}},
      '{'{REQ_READ, 3'd5, 4'd3, 64'd0, 4'd0}, 1'b1, '{ST_BADTHR, 0, 0, 0, 0, 0, 0}},
      '{'{REQ_READ, 3'd7, 4'd3, 64'd0, 4'd0}, 1'b1, '{ST_BADTHR, 0, 0, 0, 0, 0, 0}},
      '{'{REQ_END, 3'd0, 4'd0, 64'd5, 4'd0}, 1'b1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0}},
      '{'{REQ_BEGIN, 3'd4, 4'd0, 64'd5, 4'd0}, 1'b1, '{ST_BADTHR, 0, 0, 0, 0, 0, 0}},
      '{'{REQ_END, 3'd4, 4'd0, 64'd5, 4'd0}, 1'b1, '{ST_BADTHR, 0, 0, 0, 0, 0, 0}},
      '{'{REQ_UNUSED, 3'd7, 4'd15, '1, 4'd15}, 1'b1, '{ST_OK, 0, 0, 0, 0, 0, 0}},
      '{'{REQ_BEGIN, 3'd3, 4'd15, '1, 4'd0}, 1'b0, '0},
      '{'{REQ_END, 3'd3, 4'd0, 64'd9, 4'd15}, 1'b1, '{ST_OK, 64'd10, 0, 0, 0, 0, 0}},
      '{'{REQ_READ, 3'd3, 4'd15, 64'd0, 4'd0}, 1'b1, '{ST_OK, 0, 1, 10, 10, 10, 1}},
      '{'{REQ_READ, 3'd4, 4'd15, 64'd0, 4'd15}, 1'b1, '{ST_OK, 0, 0, 0, '1, 0, 1}},
      '{'{REQ_BEGIN, 3'd1, 4'd2, 64'd0, 4'd0}, 1'b0, '0},
      '{'{REQ_BEGIN, 3'd1, 4'd2, 64'd100, 4'd0}, 1'b0, '0},
      '{'{REQ_END, 3'd1, 4'd2, 64'd150, 4'd0}, 1'b0, '0},
      '{'{REQ_END, 3'd1, 4'd2, '1, 4'd0}, 1'b0, '0},
      '{'{REQ_READ, 3'd1, 4'd2, 64'd0, 4'd1}, 1'b0, '0},
      '{'{REQ_READ, 3'd4, 4'd2, 64'd0, 4'd0}, 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      send_event(rw.ev, rw.has_exp, rw.exp);
    end

    // Nesting too deep: one region opened past the level limit on thread 2.
    for (int i = 0; i <= LEVELS; i++) send_event('{REQ_BEGIN, 3'd2, 4'd7, 64'(i), 4'd0});
    // Stack full: fill the rest with other regions, then one more.
    for (int i = LEVELS; i <= STACK_DEPTH; i++)
      send_event('{REQ_BEGIN, 3'd2, 4'(i % 7), 64'(i), 4'd0});
    for (int i = 0; i < STACK_DEPTH; i++) send_event('{REQ_END, 3'd2, 4'd0, rand64(), 4'd0});
    send_event('{REQ_READ, 3'd2, 4'd7, 64'd0, 4'd15});
    drain();

    idle_pct = 0;  stall_pct = 0;  random_events(150);
    idle_pct = 69; stall_pct = 0;  random_events(150);
    drain();
    idle_pct = 0;  stall_pct = 69;
    fork
      hold_results(300);
      random_events(150);
    join
    idle_pct = 19; stall_pct = 19; random_events(150);

    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
src/nrts_pkg.sv
src/nrts_if.sv
src/nrts_alu.sv
src/nested_region_timing_stats.sv
src/nrts_chk.sv
bench/tb_top.sv
